// ===== hdl/dpa_pkg.sv =====
// Shared types and constants of the difference-of-means engine.
package dpa_pkg;

   localparam int THRESH_W    = 6;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 40;
   localparam int FRAC_W      = 16;
   localparam int DIVIDEND_W  = SUM_W + FRAC_W;
   localparam int MEAN_W      = DIVIDEND_W + 1;
   localparam int DIFF_W      = 32;
   localparam int STEP_W      = $clog2(DIVIDEND_W + 1);

   localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd4;
   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_ACCUMULATE = 2'd0,
      CMD_READ       = 2'd1,
      CMD_CLEAR      = 2'd2,
      CMD_SPARE      = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      OP_ACC   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic                       in_range;
      logic                       low_group;
      logic [2:0]                 sbox;
      logic [5:0]                 guess;
      logic [6:0]                 point;
      logic signed [SAMPLE_W-1:0] sample;
   } entry_type;

endpackage

// ===== hdl/dpa_front.sv =====
// Front end: takes request words, holds the split threshold and classifies each word.
module dpa_front #(
   parameter int NUM_SBOX    = 8,
   parameter int KEY_GUESSES = 64,
   parameter int POINTS      = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [2:0]            req_sbox_index,
   input  logic [5:0]            req_key_guess,
   input  logic [6:0]            req_point_index,
   input  logic [5:0]            req_hamming_weight,
   input  logic signed [15:0]    req_sample,
   input  logic                  csr_write_enable,
   input  logic [5:0]            csr_write_data,
   input  logic                  hold,
   input  logic                  queue_full,
   output logic                  push,
   output dpa_pkg::entry_type    push_data
);
   import dpa_pkg::*;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   op_type              op;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write_enable) begin
         thresh_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      case (command_type'(req_command))
         CMD_ACCUMULATE: op = OP_ACC;
         CMD_CLEAR:      op = OP_CLEAR;
         default:        op = OP_READ;
      endcase
   end

   assign req_stall = queue_full | hold;
   assign push      = req_valid & ~req_stall;

   always_comb begin
      push_data.op        = op;
      push_data.in_range  = (32'(req_sbox_index) < NUM_SBOX)
                          && (32'(req_key_guess) < KEY_GUESSES)
                          && (32'(req_point_index) < POINTS);
      push_data.low_group = req_hamming_weight < thresh_ff;
      push_data.sbox      = req_sbox_index;
      push_data.guess     = req_key_guess;
      push_data.point     = req_point_index;
      push_data.sample    = req_sample;
   end

endmodule

// ===== hdl/dpa_queue.sv =====
// Two-entry queue between the front end and the back end.
module dpa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dpa_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output dpa_pkg::entry_type pop_data,
   output logic               not_empty
);
   import dpa_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = fill_ff[1];
   assign not_empty = fill_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

// ===== hdl/dpa_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module dpa_div #(
   parameter int COUNT_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dpa_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [COUNT_BITS-1:0]            divisor,
   output logic                             done,
   output logic [dpa_pkg::DIVIDEND_W-1:0]   quotient
);
   import dpa_pkg::*;

   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff     = trial - {1'b0, div_ff};
      fits     = trial >= {1'b0, div_ff};
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         div_in   = divisor;
         quo_in   = dividend;
         steps_in = STEP_W'(DIVIDEND_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         steps_in = steps_ff - STEP_W'(1);
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/dpa_back.sv =====
// Back end: accumulator store, clearing pass, mean computation and result register.
module dpa_back #(
   parameter int NUM_SBOX    = 8,
   parameter int KEY_GUESSES = 64,
   parameter int POINTS      = 128,
   parameter int COUNT_BITS  = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  dpa_pkg::entry_type head,
   output logic               pop,
   output logic               hold,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_difference,
   output logic               rsp_both_groups_seen,
   output logic               rsp_count_overflow,
   output logic               rsp_clear_done
);
   import dpa_pkg::*;

   localparam int PAIRS  = NUM_SBOX * KEY_GUESSES;
   localparam int CELLS  = PAIRS * POINTS;
   localparam int PAIR_W = $clog2(PAIRS);
   localparam int CELL_W = $clog2(CELLS);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_READ      = 9'b000000010,
      ST_DIV_LOW   = 9'b000000100,
      ST_WAIT_LOW  = 9'b000001000,
      ST_DIV_HIGH  = 9'b000010000,
      ST_WAIT_HIGH = 9'b000100000,
      ST_DIFF      = 9'b001000000,
      ST_RESP      = 9'b010000000,
      ST_WIPE      = 9'b100000000
   } state_type;

   logic [SUM_W-1:0]      low_sum_mem  [CELLS];
   logic [SUM_W-1:0]      high_sum_mem [CELLS];
   logic [COUNT_BITS:0]   low_cnt_mem  [PAIRS];
   logic [COUNT_BITS:0]   high_cnt_mem [PAIRS];

   logic [SUM_W-1:0]      low_sum_rd_ff, high_sum_rd_ff;
   logic [COUNT_BITS:0]   low_cnt_rd_ff, high_cnt_rd_ff;

   state_type             state_ff, state_in;
   logic                  init_ff, init_in;
   logic [CELL_W-1:0]     wipe_ff, wipe_in;
   entry_type             cur_ff, cur_in;
   logic [PAIR_W-1:0]     pair_ff, pair_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic [SUM_W-1:0]      sl_ff, sl_in, sh_ff, sh_in;
   logic [COUNT_BITS-1:0] cl_ff, cl_in, ch_ff, ch_in;
   logic [MEAN_W-1:0]     ml_ff, ml_in, mh_ff, mh_in;
   logic [DIFF_W-1:0]     res_diff_ff, res_diff_in;
   logic                  res_both_ff, res_both_in;
   logic                  res_ovf_ff, res_ovf_in;
   logic                  res_done_ff, res_done_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DIFF_W-1:0]     out_diff_ff, out_diff_in;
   logic                  out_both_ff, out_both_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic                  out_done_ff, out_done_in;

   logic [PAIR_W-1:0]     head_pair;
   logic [CELL_W-1:0]     head_cell;
   logic                  low_sum_we, high_sum_we, low_cnt_we, high_cnt_we;
   logic [CELL_W-1:0]     sum_waddr;
   logic [PAIR_W-1:0]     cnt_waddr;
   logic [SUM_W-1:0]      sum_wdata;
   logic [COUNT_BITS:0]   cnt_wdata;

   logic [SUM_W-1:0]      sel_sum;
   logic [COUNT_BITS:0]   sel_cnt;
   logic                  full_now;
   logic [SUM_W:0]        sum_ext;
   logic [SUM_W-1:0]      new_sum;
   logic [COUNT_BITS-1:0] new_count;

   logic                  div_start, div_done;
   logic [SUM_W-1:0]      div_sum;
   logic [SUM_W-1:0]      div_mag;
   logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
   logic [COUNT_BITS-1:0] div_divisor;
   logic [MEAN_W-1:0]     signed_mean;
   logic [MEAN_W:0]       mean_diff;
   logic [MEAN_W:0]       diff_mag;
   logic                  out_free;

   assign head_pair = PAIR_W'(32'(head.sbox) * KEY_GUESSES + 32'(head.guess));
   assign head_cell = CELL_W'(32'(head_pair) * POINTS + 32'(head.point));

   always_ff @(posedge clock) begin
      if (low_sum_we) begin
         low_sum_mem[sum_waddr] <= sum_wdata;
      end
      low_sum_rd_ff <= low_sum_mem[head_cell];
   end

   always_ff @(posedge clock) begin
      if (high_sum_we) begin
         high_sum_mem[sum_waddr] <= sum_wdata;
      end
      high_sum_rd_ff <= high_sum_mem[head_cell];
   end

   always_ff @(posedge clock) begin
      if (low_cnt_we) begin
         low_cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      low_cnt_rd_ff <= low_cnt_mem[head_pair];
   end

   always_ff @(posedge clock) begin
      if (high_cnt_we) begin
         high_cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      high_cnt_rd_ff <= high_cnt_mem[head_pair];
   end

   dpa_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      sel_sum   = cur_ff.low_group ? low_sum_rd_ff : high_sum_rd_ff;
      sel_cnt   = cur_ff.low_group ? low_cnt_rd_ff : high_cnt_rd_ff;
      full_now  = sel_cnt[COUNT_BITS]
                | ((cur_ff.point == 7'd0) & (sel_cnt[COUNT_BITS-1:0] == CNT_MAX));
      new_count = sel_cnt[COUNT_BITS-1:0];
      if (!full_now && cur_ff.point == 7'd0) begin
         new_count = sel_cnt[COUNT_BITS-1:0] + COUNT_BITS'(1);
      end
      sum_ext = {sel_sum[SUM_W-1], sel_sum}
              + {{(SUM_W+1-SAMPLE_W){cur_ff.sample[SAMPLE_W-1]}}, cur_ff.sample};
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         new_sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         new_sum = sum_ext[SUM_W-1:0];
      end
      if (full_now) begin
         new_sum = sel_sum;
      end
   end

   always_comb begin
      div_sum      = (state_ff == ST_DIV_LOW) ? sl_ff : sh_ff;
      div_mag      = div_sum[SUM_W-1] ? (~div_sum + SUM_W'(1)) : div_sum;
      div_dividend = {div_mag, {FRAC_W{1'b0}}};
      div_divisor  = (state_ff == ST_DIV_LOW) ? cl_ff : ch_ff;
      div_start    = (state_ff == ST_DIV_LOW) || (state_ff == ST_DIV_HIGH);
      signed_mean  = {1'b0, div_quotient};
      if ((state_ff == ST_WAIT_LOW) ? sl_ff[SUM_W-1] : sh_ff[SUM_W-1]) begin
         signed_mean = ~{1'b0, div_quotient} + MEAN_W'(1);
      end
      mean_diff = {ml_ff[MEAN_W-1], ml_ff} - {mh_ff[MEAN_W-1], mh_ff};
      diff_mag  = mean_diff[MEAN_W] ? (~mean_diff + (MEAN_W+1)'(1)) : mean_diff;
   end

   assign out_free = ~out_valid_ff | ~rsp_stall;

   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      wipe_in     = wipe_ff;
      cur_in      = cur_ff;
      pair_in     = pair_ff;
      cell_in     = cell_ff;
      sl_in       = sl_ff;
      sh_in       = sh_ff;
      cl_in       = cl_ff;
      ch_in       = ch_ff;
      ml_in       = ml_ff;
      mh_in       = mh_ff;
      res_diff_in = res_diff_ff;
      res_both_in = res_both_ff;
      res_ovf_in  = res_ovf_ff;
      res_done_in = res_done_ff;
      pop         = 1'b0;
      low_sum_we  = 1'b0;
      high_sum_we = 1'b0;
      low_cnt_we  = 1'b0;
      high_cnt_we = 1'b0;
      sum_waddr   = cell_ff;
      cnt_waddr   = pair_ff;
      sum_wdata   = new_sum;
      cnt_wdata   = {full_now, new_count};
      out_valid_in = out_valid_ff & rsp_stall;
      out_diff_in  = out_diff_ff;
      out_both_in  = out_both_ff;
      out_ovf_in   = out_ovf_ff;
      out_done_in  = out_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop         = 1'b1;
               cur_in      = head;
               pair_in     = head_pair;
               cell_in     = head_cell;
               res_diff_in = '0;
               res_both_in = 1'b0;
               res_ovf_in  = 1'b0;
               res_done_in = 1'b0;
               if (head.op == OP_CLEAR) begin
                  wipe_in  = '0;
                  state_in = ST_WIPE;
               end else if (!head.in_range) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            sl_in = low_sum_rd_ff;
            sh_in = high_sum_rd_ff;
            cl_in = low_cnt_rd_ff[COUNT_BITS-1:0];
            ch_in = high_cnt_rd_ff[COUNT_BITS-1:0];
            if (cur_ff.op == OP_ACC) begin
               res_ovf_in = full_now;
               if (cur_ff.low_group) begin
                  low_sum_we = 1'b1;
                  low_cnt_we = 1'b1;
                  sl_in      = new_sum;
                  cl_in      = new_count;
               end else begin
                  high_sum_we = 1'b1;
                  high_cnt_we = 1'b1;
                  sh_in       = new_sum;
                  ch_in       = new_count;
               end
            end
            if ((cl_in != '0) && (ch_in != '0)) begin
               state_in = ST_DIV_LOW;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DIV_LOW: begin
            state_in = ST_WAIT_LOW;
         end
         ST_WAIT_LOW: begin
            if (div_done) begin
               ml_in    = signed_mean;
               state_in = ST_DIV_HIGH;
            end
         end
         ST_DIV_HIGH: begin
            state_in = ST_WAIT_HIGH;
         end
         ST_WAIT_HIGH: begin
            if (div_done) begin
               mh_in    = signed_mean;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            res_both_in = 1'b1;
            if (diff_mag[MEAN_W:DIFF_W] != '0) begin
               res_diff_in = '1;
            end else begin
               res_diff_in = diff_mag[DIFF_W-1:0];
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_diff_in  = res_diff_ff;
               out_both_in  = res_both_ff;
               out_ovf_in   = res_ovf_ff;
               out_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_WIPE: begin
            low_sum_we  = 1'b1;
            high_sum_we = 1'b1;
            sum_waddr   = wipe_ff;
            sum_wdata   = '0;
            cnt_waddr   = wipe_ff[PAIR_W-1:0];
            cnt_wdata   = '0;
            if (32'(wipe_ff) < PAIRS) begin
               low_cnt_we  = 1'b1;
               high_cnt_we = 1'b1;
            end
            wipe_in = wipe_ff + CELL_W'(1);
            if (wipe_ff == CELL_W'(CELLS - 1)) begin
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  res_done_in = 1'b1;
                  state_in    = ST_RESP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         init_ff      <= 1'b1;
         wipe_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         wipe_ff      <= wipe_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pair_ff     <= pair_in;
      cell_ff     <= cell_in;
      sl_ff       <= sl_in;
      sh_ff       <= sh_in;
      cl_ff       <= cl_in;
      ch_ff       <= ch_in;
      ml_ff       <= ml_in;
      mh_ff       <= mh_in;
      res_diff_ff <= res_diff_in;
      res_both_ff <= res_both_in;
      res_ovf_ff  <= res_ovf_in;
      res_done_ff <= res_done_in;
      out_diff_ff <= out_diff_in;
      out_both_ff <= out_both_in;
      out_ovf_ff  <= out_ovf_in;
      out_done_ff <= out_done_in;
   end

   assign hold                 = init_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_difference       = out_diff_ff;
   assign rsp_both_groups_seen = out_both_ff;
   assign rsp_count_overflow   = out_ovf_ff;
   assign rsp_clear_done       = out_done_ff;

endmodule

// ===== hdl/dpa_difference_of_means.sv =====
// Top level of the difference-of-means power analysis engine.
// A request word whose address is out of range goes straight to the response. One whose
// S-box and key guess still have an empty group passes the store read and is then answered.
// Otherwise the shared divider, which produces one quotient bit per cycle, computes the
// low-group mean and then the high-group mean. A clear word walks every cell of the sum
// store one cell per cycle. After reset the same pass runs while req_stall is high; the
// split threshold can be written during it. A two-word queue decouples the request side
// from the back end, and the response word sits in its own register so the back end can
// work on the next word while a response is stalled.
module dpa_difference_of_means #(
   parameter int NUM_SBOX    = 8,
   parameter int KEY_GUESSES = 64,
   parameter int POINTS      = 128,
   parameter int COUNT_BITS  = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_sbox_index,
   input  logic [5:0]         req_key_guess,
   input  logic [6:0]         req_point_index,
   input  logic [5:0]         req_hamming_weight,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_difference,
   output logic               rsp_both_groups_seen,
   output logic               rsp_count_overflow,
   output logic               rsp_clear_done,
   input  logic               csr_write_enable,
   input  logic [5:0]         csr_write_data
);
   import dpa_pkg::*;

   entry_type push_data, pop_data;
   logic      push, pop, queue_full, not_empty, hold;

   dpa_front #(
      .NUM_SBOX    (NUM_SBOX),
      .KEY_GUESSES (KEY_GUESSES),
      .POINTS      (POINTS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_sbox_index     (req_sbox_index),
      .req_key_guess      (req_key_guess),
      .req_point_index    (req_point_index),
      .req_hamming_weight (req_hamming_weight),
      .req_sample         (req_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .hold               (hold),
      .queue_full         (queue_full),
      .push               (push),
      .push_data          (push_data)
   );

   dpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   dpa_back #(
      .NUM_SBOX    (NUM_SBOX),
      .KEY_GUESSES (KEY_GUESSES),
      .POINTS      (POINTS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .not_empty            (not_empty),
      .head                 (pop_data),
      .pop                  (pop),
      .hold                 (hold),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_difference       (rsp_difference),
      .rsp_both_groups_seen (rsp_both_groups_seen),
      .rsp_count_overflow   (rsp_count_overflow),
      .rsp_clear_done       (rsp_clear_done)
   );

endmodule

// ===== hdl/dpa_checker.sv =====
// Port-level checks of the engine's response words, bound to the top level.
module dpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_difference,
   input logic        rsp_both_groups_seen,
   input logic        rsp_count_overflow,
   input logic        rsp_clear_done
);

   clear_word_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clear_done |-> rsp_difference == 32'd0
         && !rsp_both_groups_seen && !rsp_count_overflow)
      else $error("A clear response carries data.");

   no_difference_without_groups: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_both_groups_seen |-> rsp_difference == 32'd0)
      else $error("A difference is reported before both groups hold a trace.");

   overflow_not_on_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count_overflow |-> !rsp_clear_done)
      else $error("Overflow and clear completion are reported together.");

   stalled_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_difference)
         && $stable(rsp_both_groups_seen) && $stable(rsp_clear_done))
      else $error("A stalled response word changed.");

endmodule

bind dpa_difference_of_means dpa_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_difference       (rsp_difference),
   .rsp_both_groups_seen (rsp_both_groups_seen),
   .rsp_count_overflow   (rsp_count_overflow),
   .rsp_clear_done       (rsp_clear_done)
);
